// ===== rtl/fixed_point_homography_point_core_assert.svh =====
// Assertion macros for the homography point core.
// No dependencies; included by modules that carry concurrent checks.
`ifndef FIXED_POINT_HOMOGRAPHY_POINT_CORE_ASSERT_SVH
`define FIXED_POINT_HOMOGRAPHY_POINT_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define FPH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FPH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FPH_ASSERT_IMP(label, ante, cons, msg)
`define FPH_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/fph_pkg.sv =====
// Shared types, constants and saturation helper for the homography point core.
// No dependencies.
package fph_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int DIV_BITS  = 2 * FRAC_BITS + 1;
    localparam int REM_W     = DATA_W + 1;
    localparam int ADDR_W    = 5;
    localparam int PIPE_LAT  = 2 + DIV_BITS + 3;

    typedef logic signed [DATA_W-1:0] q_t;

    localparam q_t ONE_Q = q_t'(64'd1 << FRAC_BITS);
    localparam q_t Q_MAX = q_t'(32'h7FFF_FFFF);
    localparam q_t Q_MIN = q_t'(32'h8000_0000);

    typedef struct packed {
        q_t x_in;
        q_t y_in;
    } point_t;

    typedef struct packed {
        q_t   x_out;
        q_t   y_out;
        logic range_error;
    } result_t;

    typedef struct packed {
        q_t gain_xx;
        q_t gain_xy;
        q_t offset_x;
        q_t gain_yx;
        q_t gain_yy;
        q_t offset_y;
        q_t persp_y;
    } coef_t;

    typedef enum logic [2:0] {
        REG_GAIN_XX  = 3'd0,
        REG_GAIN_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_GAIN_YX  = 3'd3,
        REG_GAIN_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_PERSP_Y  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        q_t   nx;
        q_t   ny;
        logic err;
        logic neg;
        logic zero;
    } carry_t;

    typedef struct packed {
        q_t   value;
        logic sat;
    } sat_t;

    function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
        sat_t r;
        r.sat = 1'b0;
        if (v > SUM_W'(Q_MAX)) begin
            r.value = Q_MAX;
            r.sat   = 1'b1;
        end else if (v < SUM_W'(Q_MIN)) begin
            r.value = Q_MIN;
            r.sat   = 1'b1;
        end else begin
            r.value = q_t'(v);
        end
        return r;
    endfunction

endpackage

// ===== rtl/fixed_point_homography_point_core.sv =====
// Top level of the fixed-point homography point core.
// Depends on fph_pkg, fph_regs, fph_front, fph_recip, fph_back.
//
// Usage:
//   Input: a point (x_in, y_in, signed Q16.16) is taken at each rising edge
//   with start high and busy low. busy is always low: one point per cycle.
//   Output: done strobes for one cycle with result (x_out, y_out,
//   range_error). Results come back in order, through the products and
//   sums, the divider (one quotient bit per stage for 2^32 / d), and the
//   reciprocal, scaling multiply and saturation stages.
//   Throughput is one point per cycle; the divider stages set the latency.
//   Configuration: APB, seven 32-bit registers at byte addresses 0..24;
//   write only while no point is in flight.
//   Reset: the pipeline empties and coefficients return to the identity.
//   The receiver cannot stall; every result is on the port one cycle.
module fixed_point_homography_point_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  fph_pkg::point_t       point,
    output logic                  done,
    output fph_pkg::result_t      result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [fph_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import fph_pkg::*;

    coef_t               coef;
    logic                f_valid, r_valid;
    carry_t              f_carry, r_carry;
    logic [DATA_W-1:0]   f_dabs;
    logic [DIV_BITS-1:0] r_quo;

    assign busy = 1'b0;

    fph_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    fph_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .point     (point),
        .coef      (coef),
        .out_valid (f_valid),
        .out_carry (f_carry),
        .out_dabs  (f_dabs)
    );

    fph_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_carry  (f_carry),
        .in_dabs   (f_dabs),
        .out_valid (r_valid),
        .out_carry (r_carry),
        .out_quo   (r_quo)
    );

    fph_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (r_valid),
        .in_carry (r_carry),
        .in_quo   (r_quo),
        .done     (done),
        .result   (result)
    );

endmodule

// ===== rtl/fph_regs.sv =====
// APB coefficient register file of the homography point core.
// Depends on fph_pkg.
module fph_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [fph_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output fph_pkg::coef_t        coef
);
    import fph_pkg::*;

    coef_t    coef_reg;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign coef   = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '{gain_xx:  ONE_Q,
                          gain_xy:  '0,
                          offset_x: '0,
                          gain_yx:  '0,
                          gain_yy:  ONE_Q,
                          offset_y: '0,
                          persp_y:  '0};
        end
        else if (wr)
        begin
            case (idx)
                REG_GAIN_XX:  coef_reg.gain_xx  <= pwdata;
                REG_GAIN_XY:  coef_reg.gain_xy  <= pwdata;
                REG_OFFSET_X: coef_reg.offset_x <= pwdata;
                REG_GAIN_YX:  coef_reg.gain_yx  <= pwdata;
                REG_GAIN_YY:  coef_reg.gain_yy  <= pwdata;
                REG_OFFSET_Y: coef_reg.offset_y <= pwdata;
                REG_PERSP_Y:  coef_reg.persp_y  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GAIN_XX:  prdata = coef_reg.gain_xx;
            REG_GAIN_XY:  prdata = coef_reg.gain_xy;
            REG_OFFSET_X: prdata = coef_reg.offset_x;
            REG_GAIN_YX:  prdata = coef_reg.gain_yx;
            REG_GAIN_YY:  prdata = coef_reg.gain_yy;
            REG_OFFSET_Y: prdata = coef_reg.offset_y;
            REG_PERSP_Y:  prdata = coef_reg.persp_y;
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/fph_front.sv =====
// Front stages: coefficient products, then numerator and denominator sums.
// Depends on fph_pkg.
module fph_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  fph_pkg::point_t       point,
    input  fph_pkg::coef_t        coef,
    output logic                  out_valid,
    output fph_pkg::carry_t       out_carry,
    output logic [fph_pkg::DATA_W-1:0] out_dabs
);
    import fph_pkg::*;

    logic signed [PROD_W-1:0] pxx_reg, pxy_reg, pyx_reg, pyy_reg, pd_reg;
    logic                     va_reg;
    logic                     vb_reg;
    carry_t                   carry_reg;
    logic [DATA_W-1:0]        dabs_reg;

    logic signed [SUM_W-1:0]  sx, sy, sd;
    sat_t                     rx, ry, rd;
    carry_t                   carry_next;
    logic [DATA_W-1:0]        dabs_next;

    always_ff @(posedge clk)
    begin
        pxx_reg <= coef.gain_xx * point.x_in;
        pxy_reg <= coef.gain_xy * point.y_in;
        pyx_reg <= coef.gain_yx * point.x_in;
        pyy_reg <= coef.gain_yy * point.y_in;
        pd_reg  <= coef.persp_y * point.y_in;
    end

    always_comb
    begin
        sx = (SUM_W'(pxx_reg) >>> FRAC_BITS) + (SUM_W'(pxy_reg) >>> FRAC_BITS)
             + SUM_W'(coef.offset_x);
        sy = (SUM_W'(pyx_reg) >>> FRAC_BITS) + (SUM_W'(pyy_reg) >>> FRAC_BITS)
             + SUM_W'(coef.offset_y);
        sd = (SUM_W'(pd_reg) >>> FRAC_BITS) + SUM_W'(ONE_Q);
        rx = sat32(sx);
        ry = sat32(sy);
        rd = sat32(sd);
        carry_next.nx   = rx.value;
        carry_next.ny   = ry.value;
        carry_next.neg  = rd.value[DATA_W-1];
        carry_next.zero = (rd.value == '0);
        carry_next.err  = rx.sat | ry.sat | rd.sat;
        dabs_next       = rd.value[DATA_W-1] ? (~rd.value + 1'b1) : rd.value;
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        dabs_reg  <= dabs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_carry = carry_reg;
    assign out_dabs  = dabs_reg;

endmodule

// ===== rtl/fph_recip.sv =====
// Pipelined restoring divider: magnitude of 2^(2F) / |d|, one quotient bit per stage.
// Depends on fph_pkg.
module fph_recip (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  fph_pkg::carry_t       in_carry,
    input  logic [fph_pkg::DATA_W-1:0] in_dabs,
    output logic                  out_valid,
    output fph_pkg::carry_t       out_carry,
    output logic [fph_pkg::DIV_BITS-1:0] out_quo
);
    import fph_pkg::*;

    logic                vld_reg   [0:DIV_BITS];
    carry_t              carry_reg [0:DIV_BITS];
    logic [DATA_W-1:0]   dabs_reg  [0:DIV_BITS];
    logic [REM_W-1:0]    rem_reg   [0:DIV_BITS];
    logic [DIV_BITS-1:0] quo_reg   [0:DIV_BITS];

    assign vld_reg[0]   = in_valid;
    assign carry_reg[0] = in_carry;
    assign dabs_reg[0]  = in_dabs;
    assign rem_reg[0]   = '0;
    assign quo_reg[0]   = '0;

    for (genvar i = 0; i < DIV_BITS; i++)
    begin : g_stage
        logic [REM_W-1:0] trial;
        logic             fits;

        // dividend 2^(2F) has only its top bit set
        assign trial = {rem_reg[i][REM_W-2:0], (i == 0) ? 1'b1 : 1'b0};
        assign fits  = (trial >= {1'b0, dabs_reg[i]});

        always_ff @(posedge clk)
        begin
            carry_reg[i+1] <= carry_reg[i];
            dabs_reg[i+1]  <= dabs_reg[i];
            rem_reg[i+1]   <= fits ? (trial - {1'b0, dabs_reg[i]}) : trial;
            quo_reg[i+1]   <= {quo_reg[i][DIV_BITS-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else
                vld_reg[i+1] <= vld_reg[i];
        end
    end

    assign out_valid = vld_reg[DIV_BITS];
    assign out_carry = carry_reg[DIV_BITS];
    assign out_quo   = quo_reg[DIV_BITS];

endmodule

// ===== rtl/fph_back.sv =====
// Back stages: signed reciprocal with saturation, scaling products, final saturation.
// Depends on fph_pkg and the assertion macro header.
`include "fixed_point_homography_point_core_assert.svh"
module fph_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  fph_pkg::carry_t       in_carry,
    input  logic [fph_pkg::DIV_BITS-1:0] in_quo,
    output logic                  done,
    output fph_pkg::result_t      result
);
    import fph_pkg::*;

    localparam logic [DIV_BITS-1:0] POS_LIM = DIV_BITS'(Q_MAX);
    localparam logic [DIV_BITS-1:0] NEG_LIM = POS_LIM + 1'b1;

    logic                     vc_reg, vd_reg, ve_reg;
    q_t                       s_reg, s_next;
    logic                     errc_reg, errc_next;
    q_t                       nxc_reg, nyc_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg;
    logic                     errd_reg;
    result_t                  res_reg, res_next;
    sat_t                     rx, ry;

    always_comb
    begin
        s_next    = q_t'(in_quo);
        errc_next = in_carry.err;
        if (in_carry.zero)
        begin
            s_next    = Q_MAX;
            errc_next = 1'b1;
        end
        else if (in_carry.neg)
        begin
            if (in_quo > NEG_LIM)
            begin
                s_next    = Q_MIN;
                errc_next = 1'b1;
            end
            else
                s_next = q_t'(~in_quo + 1'b1);
        end
        else if (in_quo > POS_LIM)
        begin
            s_next    = Q_MAX;
            errc_next = 1'b1;
        end
    end

    always_comb
    begin
        rx = sat32(SUM_W'(px_reg) >>> FRAC_BITS);
        ry = sat32(SUM_W'(py_reg) >>> FRAC_BITS);
        res_next.x_out       = rx.value;
        res_next.y_out       = ry.value;
        res_next.range_error = errd_reg | rx.sat | ry.sat;
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        errc_reg <= errc_next;
        nxc_reg  <= in_carry.nx;
        nyc_reg  <= in_carry.ny;
        px_reg   <= nxc_reg * s_reg;
        py_reg   <= nyc_reg * s_reg;
        errd_reg <= errc_reg;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= in_valid;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    assign done   = ve_reg;
    assign result = res_reg;

    `FPH_ASSERT_IMP(a_back_lat, 1'b1, done == $past(in_valid, 3), "back latency broken")
    `FPH_ASSERT_IMP(a_zero_err, done && $past(in_valid && in_carry.zero, 3),
        result.range_error, "zero denominator without error")
    `FPH_ASSERT_IMP(a_s_nonzero, vc_reg, s_reg != '0, "reciprocal is zero")

endmodule

// ===== verif/tb_fixed_point_homography_point_core.sv =====
// Testbench for the fixed-point homography point core: APB coefficient
// writes, random and directed points, a local predictor and a result checker.
// Depends on fph_pkg and fixed_point_homography_point_core.
`timescale 1ns / 1ps
module tb_fixed_point_homography_point_core;
    import fph_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    point_t point = '0;
    logic done;
    result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    fixed_point_homography_point_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #6 clk = ~clk;

    logic signed [31:0] coef [7];
    result_t mapped_q[$];
    int errors = 0;
    int idle_cycles = 0;
    int gap_pct = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        end
    endtask

    function automatic logic signed [65:0] qmul(input logic signed [65:0] a,
                                                input logic signed [65:0] b);
        logic signed [131:0] p;
        begin
            p = a * b;
            return 66'(p >>> FRAC_BITS);
        end
    endfunction

    function automatic logic signed [65:0] clamp(input logic signed [65:0] v,
                                                 inout logic err);
        begin
            if (v > 66'sh7FFF_FFFF) begin err = 1'b1; return 66'sh7FFF_FFFF; end
            if (v < -66'sh8000_0000) begin err = 1'b1; return -66'sh8000_0000; end
            return v;
        end
    endfunction

    function automatic result_t map_point(input point_t p);
        logic err;
        logic signed [65:0] x, y, nx, ny, d, s, q;
        result_t r;
        begin
            err = 1'b0;
            x = p.x_in;
            y = p.y_in;
            nx = clamp(qmul(coef[REG_GAIN_XX], x) + qmul(coef[REG_GAIN_XY], y)
                       + coef[REG_OFFSET_X], err);
            ny = clamp(qmul(coef[REG_GAIN_YX], x) + qmul(coef[REG_GAIN_YY], y)
                       + coef[REG_OFFSET_Y], err);
            d = clamp(qmul(coef[REG_PERSP_Y], y) + (66'sd1 <<< FRAC_BITS), err);
            if (d == 0) begin
                err = 1'b1;
                s = 66'sh7FFF_FFFF;
            end else begin
                q = (66'sd1 <<< (2 * FRAC_BITS)) / d;
                s = clamp(q, err);
            end
            r.x_out = q_t'(clamp(qmul(nx, s), err));
            r.y_out = q_t'(clamp(qmul(ny, s), err));
            r.range_error = err;
            return r;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && done) begin
            if (mapped_q.size() == 0) begin
                report("unexpected beat", result.x_out, 32'h0);
            end else begin
                result_t w;
                w = mapped_q.pop_front();
                if (result.x_out !== w.x_out) report("x_out", result.x_out, w.x_out);
                if (result.y_out !== w.y_out) report("y_out", result.y_out, w.y_out);
                if (result.range_error !== w.range_error)
                    report("range_error", 32'(result.range_error), 32'(w.range_error));
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || done || (psel && penable)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_coef(input reg_idx_t idx, input logic [31:0] val);
        begin
            @(negedge clk);
            psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
            paddr = ADDR_W'(4 * int'(idx)); pwdata = val;
            @(negedge clk);
            penable = 1'b1;
            do @(posedge clk); while (!pready);
            coef[idx] = val;
            @(negedge clk);
            psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        end
    endtask

    task automatic send_point(input point_t p);
        begin
            while ($urandom_range(99) < gap_pct) @(negedge clk);
            start = 1'b1;
            point = p;
            do @(posedge clk); while (busy);
            mapped_q.push_back(map_point(p));
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic drain();
        begin
            while (mapped_q.size() != 0) @(negedge clk);
            repeat (PIPE_LAT + 4) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF);
        endcase
    endfunction

    task automatic test_identity();
        logic [31:0] edges [6];
        begin
            edges = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                      32'h5555_AAAA};
            foreach (edges[i]) send_point('{x_in: edges[i], y_in: edges[5 - i]});
            drain();
        end
    endtask

    task automatic test_extremes();
        begin
            for (int r = 0; r < 7; r++) write_coef(reg_idx_t'(r), 32'h7FFF_FFFF);
            send_point('{x_in: 32'h7FFF_FFFF, y_in: 32'h7FFF_FFFF});
            send_point('{x_in: 32'h8000_0000, y_in: 32'h0001_0000});
            drain();
            for (int r = 0; r < 7; r++) write_coef(reg_idx_t'(r), 32'h8000_0000);
            send_point('{x_in: 32'h8000_0000, y_in: 32'h8000_0000});
            send_point('{x_in: 32'h0000_0001, y_in: 32'hFFFF_FFFF});
            drain();
        end
    endtask

    task automatic test_zero_denominator();
        begin
            write_coef(REG_GAIN_XX, 32'h0001_0000);
            write_coef(REG_GAIN_XY, 32'h0);
            write_coef(REG_OFFSET_X, 32'h0);
            write_coef(REG_GAIN_YX, 32'h0);
            write_coef(REG_GAIN_YY, 32'h0);
            write_coef(REG_OFFSET_Y, 32'h0);
            write_coef(REG_PERSP_Y, 32'hFFFF_0000);
            send_point('{x_in: 32'h0002_0000, y_in: 32'h0001_0000});
            send_point('{x_in: 32'hFFFE_0000, y_in: 32'h0001_0000});
            send_point('{x_in: 32'h0, y_in: 32'h0001_0000});
            drain();
            write_coef(REG_PERSP_Y, 32'h0001_0000);
            send_point('{x_in: 32'h0003_0000, y_in: 32'hFFFF_0000});
            drain();
            write_coef(REG_PERSP_Y, 32'h0000_0400);
            send_point('{x_in: 32'h0003_0000, y_in: 32'hFFC0_0000});
            send_point('{x_in: 32'h0003_0000, y_in: 32'h0040_0000});
            drain();
        end
    endtask

    task automatic test_random(input int n_sets, input int per_set);
        begin
            for (int s = 0; s < n_sets; s++) begin
                for (int r = 0; r < 7; r++) begin
                    if (r == int'(REG_PERSP_Y) && $urandom_range(2) != 0)
                        write_coef(reg_idx_t'(r), 32'($signed($urandom_range(0, 32'h3FF)) - 512));
                    else
                        write_coef(reg_idx_t'(r), rand_q());
                end
                for (int i = 0; i < per_set; i++)
                    send_point('{x_in: rand_q(), y_in: rand_q()});
                drain();
            end
            drain();
        end
    endtask

    initial begin
        coef[REG_GAIN_XX] = ONE_Q; coef[REG_GAIN_XY] = '0; coef[REG_OFFSET_X] = '0;
        coef[REG_GAIN_YX] = '0; coef[REG_GAIN_YY] = ONE_Q; coef[REG_OFFSET_Y] = '0;
        coef[REG_PERSP_Y] = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        gap_pct = 6;
        test_identity();
        test_extremes();
        test_zero_denominator();
        test_random(20, 30);
        gap_pct = 64;
        test_random(20, 30);
        gap_pct = 0;
        test_random(20, 30);
        drain();
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
